@@ hdl/bdf_velocity_estimator_core_macros.svh @@
// assertion macros for the velocity estimator core
// the checking forms are compiled out for synthesis
`ifndef BDF_VELOCITY_ESTIMATOR_CORE_MACROS_SVH
`define BDF_VELOCITY_ESTIMATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// condition implies consequence in the same cycle
`define BDFVE_ASSERT_HOLDS(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define BDFVE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BDFVE_ASSERT_HOLDS(lbl, clk, rst, ante, cons, msg)
`define BDFVE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ hdl/bdfve_pkg.sv @@
package bdfve_pkg;

  // sizes
  localparam int JOINTS     = 8;
  localparam int HIST_DEPTH = 7;
  localparam int JOINT_W    = 3;
  localparam int DATA_W     = 32;
  localparam int DT_W       = 20;
  localparam int ORDER_W    = 3;
  localparam int TAP_W      = 3;
  localparam int COEF_W     = 11;
  localparam int GAIN_W     = 6;
  localparam int DEN_W      = 26;
  localparam int MAG_W      = 44;
  localparam int MAG_SPLIT  = 22;
  localparam int NUM_W      = 63;
  localparam int Q_W        = 32;
  localparam int MAC_A_W    = 33;
  localparam int MAC_B_W    = 21;
  localparam int PROD_W     = MAC_A_W + MAC_B_W;
  localparam int ACC_W      = 64;
  localparam int FILT_LSB   = 16;

  // constants
  localparam int ORDER_RESET = 3;
  localparam int W_FILT      = 58982;
  localparam int W_PREV      = 6554;
  localparam int ROUND_BIAS  = 32768;
  localparam int VEL_SCALE   = 1000000;
  localparam logic [DATA_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] VEL_MIN = 32'h8000_0000;

  typedef logic signed [COEF_W-1:0] coef_t;

  // control of the shared multiply-accumulate unit
  typedef struct packed {
    logic en;
    logic clr;
    logic shl;
  } mac_op_t;

  // order register value to the order used, 1 to 6
  function automatic logic [ORDER_W-1:0] clamp_order(input logic [ORDER_W-1:0] v);
    logic [ORDER_W-1:0] r;
    r = v;
    if (v == ORDER_W'(0)) r = ORDER_W'(1);
    if (v == ORDER_W'(7)) r = ORDER_W'(6);
    return r;
  endfunction

  // integer bdf coefficient of one tap, zero beyond the order
  function automatic coef_t bdf_tap(input logic [ORDER_W-1:0] ord,
                                    input logic [TAP_W-1:0] tap);
    coef_t row [8];
    unique case (ord)
      3'd1: row = '{11'sd1, -11'sd1, 11'sd0, 11'sd0, 11'sd0, 11'sd0, 11'sd0, 11'sd0};
      3'd2: row = '{11'sd3, -11'sd4, 11'sd1, 11'sd0, 11'sd0, 11'sd0, 11'sd0, 11'sd0};
      3'd3: row = '{11'sd11, -11'sd18, 11'sd9, -11'sd2, 11'sd0, 11'sd0, 11'sd0, 11'sd0};
      3'd4: row = '{11'sd25, -11'sd48, 11'sd36, -11'sd16, 11'sd3, 11'sd0, 11'sd0, 11'sd0};
      3'd5: row = '{11'sd137, -11'sd300, 11'sd300, -11'sd200, 11'sd75, -11'sd12, 11'sd0,
                    11'sd0};
      default: row = '{11'sd147, -11'sd360, 11'sd450, -11'sd400, 11'sd225, -11'sd72,
                       11'sd10, 11'sd0};
    endcase
    return row[tap];
  endfunction

  // gain of the order, applied to the interval
  function automatic logic [GAIN_W-1:0] bdf_gain(input logic [ORDER_W-1:0] ord);
    logic [GAIN_W-1:0] g;
    unique case (ord)
      3'd1: g = GAIN_W'(1);
      3'd2: g = GAIN_W'(2);
      3'd3: g = GAIN_W'(6);
      3'd4: g = GAIN_W'(12);
      default: g = GAIN_W'(60);
    endcase
    return g;
  endfunction

endpackage

@@ hdl/bdfve_hist.sv @@
module bdfve_hist #(
  parameter int JOINTS = bdfve_pkg::JOINTS,
  localparam int SLOT_W = (JOINTS > 1) ? $clog2(JOINTS) : 1
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [SLOT_W-1:0]                      slot,
  input  logic                                   rd_en,
  input  logic [bdfve_pkg::TAP_W-1:0]            rd_tap,
  output logic signed [bdfve_pkg::DATA_W-1:0]    rd_data,
  input  logic                                   wr_en,
  input  logic [bdfve_pkg::TAP_W-1:0]            wr_tap,
  input  logic signed [bdfve_pkg::DATA_W-1:0]    wr_data
);

  localparam int DEPTH  = JOINTS * bdfve_pkg::HIST_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);

  logic signed [bdfve_pkg::DATA_W-1:0] hist_mem [DEPTH];
  logic [DEPTH-1:0]                    vld;
  logic [ADDR_W-1:0]                   rd_addr;
  logic [ADDR_W-1:0]                   wr_addr;
  logic signed [bdfve_pkg::DATA_W-1:0] rd_q;
  logic                                rd_vld;

  // row per joint, entry 0 newest
  assign rd_addr = ADDR_W'(slot) * ADDR_W'(bdfve_pkg::HIST_DEPTH) + ADDR_W'(rd_tap);
  assign wr_addr = ADDR_W'(slot) * ADDR_W'(bdfve_pkg::HIST_DEPTH) + ADDR_W'(wr_tap);

  // storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_data;
    end
  end

  // registered read with its valid bit
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q   <= hist_mem[rd_addr];
      rd_vld <= vld[rd_addr];
    end
  end

  // per-entry valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // unwritten entries read as zero
  assign rd_data = rd_vld ? rd_q : '0;

endmodule

@@ hdl/bdfve_mac.sv @@
module bdfve_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bdfve_pkg::mac_op_t                    op,
  input  logic signed [bdfve_pkg::MAC_A_W-1:0]  a,
  input  logic signed [bdfve_pkg::MAC_B_W-1:0]  b,
  output logic signed [bdfve_pkg::ACC_W-1:0]    acc
);

  localparam int PROD_W = bdfve_pkg::PROD_W;
  localparam int ACC_W  = bdfve_pkg::ACC_W;
  localparam int SH     = bdfve_pkg::MAG_SPLIT;

  logic signed [PROD_W-1:0] prod;
  bdfve_pkg::mac_op_t       op_q;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  acc_next;

  // product register
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  // operation follows its product
  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= '0;
    end else begin
      op_q <= op;
    end
  end

  // accumulate, optionally with the product shifted up
  always_comb begin
    prod_ext = {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    addend   = op_q.shl ? {prod_ext[ACC_W-SH-1:0], {SH{1'b0}}} : prod_ext;
    acc_next = op_q.clr ? addend : acc + addend;
  end

  always_ff @(posedge clk) begin
    if (op_q.en) begin
      acc <= acc_next;
    end
  end

endmodule

@@ hdl/bdfve_div.sv @@
module bdfve_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [bdfve_pkg::NUM_W-1:0]      num,
  input  logic [bdfve_pkg::DEN_W-1:0]      den,
  output logic                             done,
  output logic [bdfve_pkg::Q_W-1:0]        quot,
  output logic                             ovf
);

  localparam int Q_W   = bdfve_pkg::Q_W;
  localparam int DEN_W = bdfve_pkg::DEN_W;
  localparam int CNT_W = $clog2(Q_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;
  logic [DEN_W-1:0] rem_next;

  // one quotient bit per cycle
  always_comb begin
    trial    = {rem, quot[Q_W-1]};
    diff     = trial - {1'b0, den};
    fits     = trial >= {1'b0, den};
    rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  // iteration counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(Q_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // quotient wider than 32 bits is flagged at once, the rest shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      ovf  <= num[bdfve_pkg::NUM_W-1:Q_W] >= (bdfve_pkg::NUM_W - Q_W)'(den);
      rem  <= num[Q_W+DEN_W-1:Q_W];
      quot <= num[Q_W-1:0];
    end else if (cnt != '0) begin
      rem  <= rem_next;
      quot <= {quot[Q_W-2:0], fits};
    end
  end

endmodule

@@ hdl/bdf_velocity_estimator_core.sv @@
// velocity estimator core: per-joint filtered position and bdf derivative
//
// input channel: in_valid / in_stall with joint_index, position,
// measured_velocity and sample_interval; a transaction is taken when
// in_valid is high and in_stall is low
// output channel: out_valid / out_stall with joint_echo, filtered_position,
// velocity_estimate and saturated, one result per input transaction
// config channel: cfg_valid / cfg_ready with cfg_data, the bdf order;
// cfg_ready is always high, write only while the core is idle
//
// from accept to out_valid a sample runs 19 sequencer steps on the shared
// multiply-accumulate unit and the history memory port, then the bit-serial
// divider up to its done pulse, then the finish state that forms the result;
// a new sample is taken only once that result is in the output register
// reset empties the output register, clears all joint histories to zero and
// sets the order to 3; a stalled result stays in the output register, the
// next sample may be processed meanwhile but is held until it is taken
`include "bdf_velocity_estimator_core_macros.svh"

module bdf_velocity_estimator_core #(
  parameter int JOINTS = bdfve_pkg::JOINTS
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [bdfve_pkg::ORDER_W-1:0]           cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [bdfve_pkg::JOINT_W-1:0]           joint_index,
  input  logic signed [bdfve_pkg::DATA_W-1:0]     position,
  input  logic signed [bdfve_pkg::DATA_W-1:0]     measured_velocity,
  input  logic [bdfve_pkg::DT_W-1:0]              sample_interval,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [bdfve_pkg::JOINT_W-1:0]           joint_echo,
  output logic signed [bdfve_pkg::DATA_W-1:0]     filtered_position,
  output logic signed [bdfve_pkg::DATA_W-1:0]     velocity_estimate,
  output logic                                    saturated
);

  localparam int SLOT_W  = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int STEP_W  = 5;
  localparam int DATA_W  = bdfve_pkg::DATA_W;
  localparam int MAC_A_W = bdfve_pkg::MAC_A_W;
  localparam int MAC_B_W = bdfve_pkg::MAC_B_W;
  localparam int MAG_W   = bdfve_pkg::MAG_W;
  localparam int SPLIT   = bdfve_pkg::MAG_SPLIT;
  localparam int DEN_W   = bdfve_pkg::DEN_W;
  localparam int TAP_W   = bdfve_pkg::TAP_W;

  // sequencer steps
  localparam logic [STEP_W-1:0] STEP_RD_H0       = 5'd0;
  localparam logic [STEP_W-1:0] STEP_MUL_POS     = 5'd1;
  localparam logic [STEP_W-1:0] STEP_MUL_PREV    = 5'd2;
  localparam logic [STEP_W-1:0] STEP_MUL_BIAS    = 5'd3;
  localparam logic [STEP_W-1:0] STEP_FILT        = 5'd5;
  localparam logic [STEP_W-1:0] STEP_SHIFT_FIRST = 5'd6;
  localparam logic [STEP_W-1:0] STEP_SHIFT_LAST  = 5'd10;
  localparam logic [STEP_W-1:0] STEP_WR_H1       = 5'd11;
  localparam logic [STEP_W-1:0] STEP_WR_H0       = 5'd12;
  localparam logic [STEP_W-1:0] STEP_SUM         = 5'd13;
  localparam logic [STEP_W-1:0] STEP_MUL_LO      = 5'd14;
  localparam logic [STEP_W-1:0] STEP_MUL_HI      = 5'd15;
  localparam logic [STEP_W-1:0] STEP_MUL_HALF    = 5'd16;
  localparam logic [STEP_W-1:0] STEP_DIV         = 5'd18;
  localparam logic [STEP_W-1:0] STEP_TAP_BASE    = 5'd12;
  localparam logic [STEP_W-1:0] STEP_RD_BASE     = 5'd10;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RUN  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t                              state;
  state_t                              state_next;
  logic [STEP_W-1:0]                   step;
  logic [bdfve_pkg::ORDER_W-1:0]       bdf_order;

  // captured transaction
  logic [bdfve_pkg::JOINT_W-1:0]       joint;
  logic [SLOT_W-1:0]                   slot;
  logic [SLOT_W-1:0]                   slot_in;
  logic signed [DATA_W-1:0]            pos;
  logic signed [DATA_W-1:0]            meas;
  logic [bdfve_pkg::DT_W-1:0]          dt;
  logic [bdfve_pkg::ORDER_W-1:0]       order;

  // working registers
  logic signed [DATA_W-1:0]            h0;
  logic signed [DATA_W-1:0]            filt;
  logic signed [DATA_W-1:0]            filt_now;
  logic [MAG_W-1:0]                    mag;
  logic                                neg;
  logic                                sum_zero;
  logic [DEN_W-1:0]                    den;

  // shared unit and memory hookup
  bdfve_pkg::mac_op_t                  mac_op;
  logic signed [MAC_A_W-1:0]           mac_a;
  logic signed [MAC_B_W-1:0]           mac_b;
  logic signed [bdfve_pkg::ACC_W-1:0]  acc;
  logic                                rd_en;
  logic [TAP_W-1:0]                    rd_tap;
  logic signed [DATA_W-1:0]            rd_data;
  logic                                wr_en;
  logic [TAP_W-1:0]                    wr_tap;
  logic signed [DATA_W-1:0]            wr_data;
  logic [STEP_W-1:0]                   tap_up;
  logic [STEP_W-1:0]                   tap_rd;
  logic                                div_start;
  logic                                div_done;
  logic [bdfve_pkg::Q_W-1:0]           quot;
  logic                                div_ovf;

  // result forming
  logic                                in_fire;
  logic                                out_load;
  logic                                dt_zero;
  logic                                q_big;
  logic [DATA_W-1:0]                   limit;
  logic [DATA_W-1:0]                   vel_res;
  logic                                sat_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_load  = (state == ST_FIN) && (!out_valid || !out_stall);

  // joint index to history row
  always_comb begin
    slot_in = '0;
    for (int i = 0; i < 8; i++) begin
      if (joint_index == bdfve_pkg::JOINT_W'(i)) begin
        slot_in = SLOT_W'(i % JOINTS);
      end
    end
  end

  // order register
  always_ff @(posedge clk) begin
    if (rst) begin
      bdf_order <= bdfve_pkg::ORDER_W'(bdfve_pkg::ORDER_RESET);
    end else if (cfg_valid && cfg_ready) begin
      bdf_order <= cfg_data;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_fire) state_next = ST_RUN;
      ST_RUN:  if (step == STEP_DIV) state_next = ST_DIV;
      ST_DIV:  if (div_done) state_next = ST_FIN;
      ST_FIN:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == ST_RUN) begin
        step <= step + 1'b1;
      end else begin
        step <= '0;
      end
    end
  end

  // step decode: memory port and shared unit operands
  always_comb begin
    mac_op    = '0;
    mac_a     = '0;
    mac_b     = '0;
    rd_en     = 1'b0;
    rd_tap    = '0;
    wr_en     = 1'b0;
    wr_tap    = '0;
    wr_data   = '0;
    div_start = 1'b0;
    filt_now  = acc[bdfve_pkg::FILT_LSB +: DATA_W];
    tap_up    = STEP_TAP_BASE - step;
    tap_rd    = STEP_RD_BASE - step;
    if (state == ST_RUN) begin
      // read older taps, newest last
      if (step >= STEP_FILT && step < STEP_SHIFT_LAST) begin
        rd_en  = 1'b1;
        rd_tap = tap_rd[TAP_W-1:0];
      end
      // shift each tap one place older and weigh it
      if (step >= STEP_SHIFT_FIRST && step <= STEP_SHIFT_LAST) begin
        wr_en   = 1'b1;
        wr_tap  = tap_up[TAP_W-1:0];
        wr_data = rd_data;
        mac_op  = '{en: 1'b1, clr: 1'b0, shl: 1'b0};
        mac_a   = MAC_A_W'(rd_data);
        mac_b   = MAC_B_W'(bdfve_pkg::bdf_tap(order, tap_up[TAP_W-1:0]));
      end
      unique case (step)
        STEP_RD_H0: begin
          rd_en = 1'b1;
        end
        STEP_MUL_POS: begin
          mac_op = '{en: 1'b1, clr: 1'b1, shl: 1'b0};
          mac_a  = MAC_A_W'(pos);
          mac_b  = MAC_B_W'(bdfve_pkg::W_FILT);
        end
        STEP_MUL_PREV: begin
          mac_op = '{en: 1'b1, clr: 1'b0, shl: 1'b0};
          mac_a  = MAC_A_W'(h0);
          mac_b  = MAC_B_W'(bdfve_pkg::W_PREV);
        end
        STEP_MUL_BIAS: begin
          mac_op = '{en: 1'b1, clr: 1'b0, shl: 1'b0};
          mac_a  = MAC_A_W'(1);
          mac_b  = MAC_B_W'(bdfve_pkg::ROUND_BIAS);
        end
        STEP_FILT: begin
          mac_op = '{en: 1'b1, clr: 1'b1, shl: 1'b0};
          mac_a  = MAC_A_W'(filt_now);
          mac_b  = MAC_B_W'(bdfve_pkg::bdf_tap(order, TAP_W'(0)));
        end
        STEP_WR_H1: begin
          wr_en   = 1'b1;
          wr_tap  = TAP_W'(1);
          wr_data = h0;
          mac_op  = '{en: 1'b1, clr: 1'b0, shl: 1'b0};
          mac_a   = MAC_A_W'(h0);
          mac_b   = MAC_B_W'(bdfve_pkg::bdf_tap(order, TAP_W'(1)));
        end
        STEP_WR_H0: begin
          wr_en   = 1'b1;
          wr_tap  = TAP_W'(0);
          wr_data = filt;
        end
        STEP_SUM: begin
          mac_op = '{en: 1'b1, clr: 1'b1, shl: 1'b0};
          mac_a  = MAC_A_W'(dt);
          mac_b  = MAC_B_W'(bdfve_pkg::bdf_gain(order));
        end
        STEP_MUL_LO: begin
          mac_op = '{en: 1'b1, clr: 1'b1, shl: 1'b0};
          mac_a  = MAC_A_W'(mag[SPLIT-1:0]);
          mac_b  = MAC_B_W'(bdfve_pkg::VEL_SCALE);
        end
        STEP_MUL_HI: begin
          mac_op = '{en: 1'b1, clr: 1'b0, shl: 1'b1};
          mac_a  = MAC_A_W'(mag[MAG_W-1:SPLIT]);
          mac_b  = MAC_B_W'(bdfve_pkg::VEL_SCALE);
        end
        STEP_MUL_HALF: begin
          mac_op = '{en: 1'b1, clr: 1'b0, shl: 1'b0};
          mac_a  = MAC_A_W'(den[DEN_W-1:1]);
          mac_b  = MAC_B_W'(1);
        end
        STEP_DIV: begin
          div_start = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // capture the transaction and intermediate values
  always_ff @(posedge clk) begin
    if (in_fire) begin
      joint <= joint_index;
      slot  <= slot_in;
      pos   <= position;
      meas  <= measured_velocity;
      dt    <= sample_interval;
      order <= bdfve_pkg::clamp_order(bdf_order);
    end
    if (state == ST_RUN && step == STEP_MUL_POS) begin
      h0 <= rd_data;
    end
    if (state == ST_RUN && step == STEP_FILT) begin
      filt <= filt_now;
    end
    if (state == ST_RUN && step == STEP_SUM) begin
      neg      <= acc[bdfve_pkg::ACC_W-1];
      sum_zero <= (acc == '0);
      mag      <= acc[bdfve_pkg::ACC_W-1] ? MAG_W'(-acc) : MAG_W'(acc);
    end
    if (state == ST_RUN && step == STEP_MUL_HI) begin
      den <= acc[DEN_W-1:0];
    end
  end

  bdfve_hist #(
    .JOINTS (JOINTS)
  ) u_hist (
    .clk     (clk),
    .rst     (rst),
    .slot    (slot),
    .rd_en   (rd_en),
    .rd_tap  (rd_tap),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_tap  (wr_tap),
    .wr_data (wr_data)
  );

  bdfve_mac u_mac (
    .clk (clk),
    .rst (rst),
    .op  (mac_op),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  bdfve_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (acc[bdfve_pkg::NUM_W-1:0]),
    .den   (den),
    .done  (div_done),
    .quot  (quot),
    .ovf   (div_ovf)
  );

  // fallback, zero interval and overflow handling
  always_comb begin
    dt_zero = (dt == '0);
    limit   = neg ? bdfve_pkg::VEL_MIN : bdfve_pkg::VEL_MAX;
    q_big   = div_ovf || (!neg && quot[bdfve_pkg::Q_W-1]) ||
              (neg && (quot > bdfve_pkg::VEL_MIN));
    priority if (sum_zero) begin
      vel_res = meas;
      sat_res = dt_zero;
    end else if (dt_zero || q_big) begin
      vel_res = limit;
      sat_res = 1'b1;
    end else begin
      vel_res = neg ? DATA_W'(-quot) : DATA_W'(quot);
      sat_res = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      joint_echo        <= joint;
      filtered_position <= filt;
      velocity_estimate <= vel_res;
      saturated         <= sat_res;
    end
  end

  // checks
  `BDFVE_ASSERT_NEXT(a_accept_starts_run, clk, rst, in_valid && !in_stall, (state == ST_RUN) && (step == '0), "sequence did not start after an accepted transaction")
  `BDFVE_ASSERT_HOLDS(a_div_done_in_div, clk, rst, div_done, state == ST_DIV, "divider finished outside the divide phase")
  `BDFVE_ASSERT_HOLDS(a_hist_write_in_run, clk, rst, wr_en, state == ST_RUN, "history written outside the run phase")
  `BDFVE_ASSERT_HOLDS(a_result_from_fin, clk, rst, $rose(out_valid), $past(state) == ST_FIN, "result appeared without a finished item")

endmodule

@@ test/bdf_velocity_estimator_core_checker.sv @@
`timescale 1ns / 1ps
module bdf_velocity_estimator_core_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [bdfve_pkg::ORDER_W-1:0]       cfg_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [bdfve_pkg::JOINT_W-1:0]       joint_index,
  input  logic signed [bdfve_pkg::DATA_W-1:0] position,
  input  logic signed [bdfve_pkg::DATA_W-1:0] measured_velocity,
  input  logic [bdfve_pkg::DT_W-1:0]          sample_interval,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [bdfve_pkg::JOINT_W-1:0]       joint_echo,
  input  logic signed [bdfve_pkg::DATA_W-1:0] filtered_position,
  input  logic signed [bdfve_pkg::DATA_W-1:0] velocity_estimate,
  input  logic                                saturated,
  output int                                  failures,
  output int                                  samples_taken,
  output int                                  results_taken
);

  typedef struct packed {
    logic [bdfve_pkg::JOINT_W-1:0] joint;
    logic [bdfve_pkg::DATA_W-1:0]  filt;
    logic [bdfve_pkg::DATA_W-1:0]  vel;
    logic                          sat;
  } joint_estimate_t;

  // filtered position history per joint, entry 0 newest
  longint                        history [8][7];
  logic [bdfve_pkg::ORDER_W-1:0] order_reg;
  longint                        coef_tab [1:6][0:6];
  longint unsigned               gain_tab [1:6];
  joint_estimate_t               pending_estimates [$];

  // integer bdf coefficients scaled to a common denominator, and the gains
  initial begin
    coef_tab[1] = '{1, -1, 0, 0, 0, 0, 0};
    coef_tab[2] = '{3, -4, 1, 0, 0, 0, 0};
    coef_tab[3] = '{11, -18, 9, -2, 0, 0, 0};
    coef_tab[4] = '{25, -48, 36, -16, 3, 0, 0};
    coef_tab[5] = '{137, -300, 300, -200, 75, -12, 0};
    coef_tab[6] = '{147, -360, 450, -400, 225, -72, 10};
    gain_tab    = '{1, 2, 6, 12, 60, 60};
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    failures = failures + 1;
  endtask

  // filter the sample, push it into the joint history, derive the velocity
  function automatic joint_estimate_t estimate_joint(
      input logic [bdfve_pkg::JOINT_W-1:0] joint,
      input logic signed [31:0] pos,
      input logic signed [31:0] meas,
      input logic [bdfve_pkg::DT_W-1:0] dt);
    joint_estimate_t est;
    longint          filt;
    longint          acc;
    longint          signed_vel;
    longint unsigned mag;
    longint unsigned den;
    longint unsigned quot;
    int              ord;
    filt = (longint'(pos) * 58982 + history[joint][0] * 6554 + 32768) >>> 16;
    for (int k = 6; k > 0; k--) history[joint][k] = history[joint][k-1];
    history[joint][0] = filt;

    // order codes 0 and 7 fold onto the nearest valid order
    ord = (order_reg == 0) ? 1 : (order_reg == 7) ? 6 : int'(order_reg);
    acc = 0;
    for (int k = 0; k <= ord; k++) acc += coef_tab[ord][k] * history[joint][k];

    est.joint = joint;
    est.filt  = filt[31:0];
    est.sat   = 1'b0;
    if (acc == 0) begin
      // flat history: fall back to the drive velocity, whatever dt is
      est.vel = meas;
      est.sat = (dt == 0);
    end else if (dt == 0) begin
      est.sat = 1'b1;
      est.vel = (acc > 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
    end else begin
      // magnitude division, rounded half away from zero
      mag  = (acc < 0) ? -acc : acc;
      den  = gain_tab[ord] * dt;
      quot = (mag * 64'd1000000 + den / 2) / den;
      if (acc > 0 && quot > 64'h7FFF_FFFF) begin
        est.sat = 1'b1;
        est.vel = 32'h7FFF_FFFF;
      end else if (acc < 0 && quot > 64'h8000_0000) begin
        est.sat = 1'b1;
        est.vel = 32'h8000_0000;
      end else begin
        signed_vel = (acc < 0) ? -longint'(quot) : longint'(quot);
        est.vel    = signed_vel[31:0];
      end
    end
    return est;
  endfunction

  // watch the three channels at each rising edge
  always @(posedge clk) begin
    joint_estimate_t want;
    joint_estimate_t fresh;
    if (rst) begin
      for (int j = 0; j < 8; j++) begin
        for (int k = 0; k < 7; k++) history[j][k] = 0;
      end
      order_reg = 3;
      pending_estimates.delete();
      failures = 0;
      samples_taken <= 0;
      results_taken <= 0;
    end else begin
      if (cfg_valid && cfg_ready) order_reg = cfg_data;

      if (in_valid && !in_stall) begin
        fresh = estimate_joint(joint_index, position, measured_velocity, sample_interval);
        pending_estimates = {pending_estimates, fresh};
        samples_taken <= samples_taken + 1;
      end

      if (out_valid && !out_stall) begin
        results_taken <= results_taken + 1;
        if (pending_estimates.size() == 0) begin
          report_mismatch("result with no sample pending", velocity_estimate, 32'h0);
        end else begin
          want = pending_estimates.pop_front();
          if (joint_echo !== want.joint)
            report_mismatch("joint_echo", 32'(joint_echo), 32'(want.joint));
          if (filtered_position !== want.filt)
            report_mismatch("filtered_position", filtered_position, want.filt);
          if (velocity_estimate !== want.vel)
            report_mismatch("velocity_estimate", velocity_estimate, want.vel);
          if (saturated !== want.sat)
            report_mismatch("saturated", 32'(saturated), 32'(want.sat));
        end
      end
    end
  end

endmodule

@@ test/bdf_velocity_estimator_core_test.sv @@
`timescale 1ns / 1ps
module bdf_velocity_estimator_core_test;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [bdfve_pkg::ORDER_W-1:0]       cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [bdfve_pkg::JOINT_W-1:0]       joint_index = '0;
  logic signed [bdfve_pkg::DATA_W-1:0] position = '0;
  logic signed [bdfve_pkg::DATA_W-1:0] measured_velocity = '0;
  logic [bdfve_pkg::DT_W-1:0]          sample_interval = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [bdfve_pkg::JOINT_W-1:0]       joint_echo;
  logic signed [bdfve_pkg::DATA_W-1:0] filtered_position;
  logic signed [bdfve_pkg::DATA_W-1:0] velocity_estimate;
  logic                                saturated;

  int                                  failures;
  int                                  samples_taken;
  int                                  results_taken;
  logic                                idle_on = 1'b1;
  logic signed [31:0]                  last_pos [8];
  logic [bdfve_pkg::ORDER_W-1:0]       order_sweep [7] = '{1, 2, 4, 5, 6, 0, 7};

  always #1 clk = ~clk;

  bdf_velocity_estimator_core uut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .joint_index       (joint_index),
    .position          (position),
    .measured_velocity (measured_velocity),
    .sample_interval   (sample_interval),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .joint_echo        (joint_echo),
    .filtered_position (filtered_position),
    .velocity_estimate (velocity_estimate),
    .saturated         (saturated)
  );

  bdf_velocity_estimator_core_checker estimate_checker (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .joint_index       (joint_index),
    .position          (position),
    .measured_velocity (measured_velocity),
    .sample_interval   (sample_interval),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .joint_echo        (joint_echo),
    .filtered_position (filtered_position),
    .velocity_estimate (velocity_estimate),
    .saturated         (saturated),
    .failures          (failures),
    .samples_taken     (samples_taken),
    .results_taken     (results_taken)
  );

  // result side backpressure in random bursts
  always begin
    @(posedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    out_stall <= 1'b0;
  end

  // one sample transaction, with an optional gap before it
  task automatic drive_sample(input logic [2:0] joint, input logic signed [31:0] pos,
                              input logic signed [31:0] meas, input logic [19:0] dt);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    joint_index       <= joint;
    position          <= pos;
    measured_velocity <= meas;
    sample_interval   <= dt;
    last_pos[joint] = pos;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending and wait until every sample has its result
  task automatic wait_drained;
    in_valid <= 1'b0;
    do @(posedge clk); while (samples_taken != results_taken);
  endtask

  task automatic set_order(input logic [2:0] ord);
    wait_drained;
    cfg_valid <= 1'b1;
    cfg_data  <= ord;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                 phase;
    int                 n;
    int                 pick;
    int                 sh;
    logic [2:0]         joint;
    logic signed [31:0] pos;
    logic [19:0]        dt;
    for (int j = 0; j < 8; j++) last_pos[j] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty history gives a zero derivative: drive velocity passes through
    drive_sample(3'd0, 32'sh0, 32'h1234_5678, 20'd1000);
    drive_sample(3'd0, 32'sh0, 32'h8000_0000, 20'd0);
    // full-scale steps: overflow, then zero interval, both signs
    drive_sample(3'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'd1);
    drive_sample(3'd1, 32'h7FFF_FFFF, 32'h0, 20'd0);
    drive_sample(3'd2, 32'h8000_0000, 32'h0, 20'd1);
    drive_sample(3'd2, 32'h8000_0000, 32'hFFFF_FFFF, 20'd0);
    drive_sample(3'd3, 32'h0100_0000, 32'h0, 20'hF_FFFF);
    for (int j = 4; j < 8; j++) drive_sample(3'(j), $urandom, $urandom, 20'd1000);

    // every order but the reset order 3, then the out-of-range codes
    for (int i = 0; i < 7; i++) begin
      set_order(order_sweep[i]);
      repeat (2) begin
        joint = 3'($urandom_range(0, 7));
        drive_sample(joint, last_pos[joint] + $urandom_range(0, 1 << 16) - (1 << 15),
                     $urandom, 20'($urandom_range(100, 5000)));
      end
    end

    // random phases: smooth trajectories mostly, plus holds and jumps;
    // one quiet phase in the middle and no idling at the end
    for (phase = 0; phase < 10; phase++) begin
      idle_on <= (phase < 8) && (phase != 3);
      set_order(3'($urandom_range(0, 7)));
      for (n = 0; n < 50; n++) begin
        joint = 3'($urandom_range(0, 7));
        pick  = $urandom_range(0, 9);
        sh    = $urandom_range(4, 20);
        if (pick < 6)
          pos = last_pos[joint] + $urandom_range(0, 1 << sh) - (1 << (sh - 1));
        else if (pick == 6)
          pos = last_pos[joint];
        else
          pos = $urandom;
        pick = $urandom_range(0, 19);
        if (pick == 0)
          dt = '0;
        else if (pick == 1)
          dt = 20'($urandom);
        else if (pick == 2)
          dt = 20'd1;
        else
          dt = 20'($urandom_range(100, 5000));
        drive_sample(joint, pos, $urandom, dt);
      end
    end

    wait_drained;
    repeat (60) @(posedge clk);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
